// File: design/http_request_url_host_extractor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HTTP request URL and Host extractor.
// The checking forms are compiled unless SYNTH is defined, in which case
// every macro expands to nothing.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_URL_HOST_EXTRACTOR_ASSERT_SVH
`define HTTP_REQUEST_URL_HOST_EXTRACTOR_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define HRX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hrx: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define HRX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hrx: next-cycle property failed");

`else

`define HRX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HRX_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/hrx_pkg.sv
// ---------------------------------------------------------------------------
// hrx_pkg
// Shared types, codes, sizes and match patterns of the HTTP request URL and
// Host extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package hrx_pkg;

    // Store sizes and payload length limit.
    localparam int URL_MAX     = 1024;
    localparam int HOST_MAX    = 256;
    localparam int PAYLOAD_MAX = 2047;

    // Derived widths.
    localparam int CNT_W   = $clog2(PAYLOAD_MAX + 1);
    localparam int CNT1_W  = CNT_W + 1;
    localparam int URL_AW  = $clog2(URL_MAX);
    localparam int HOST_AW = $clog2(HOST_MAX);

    // Fixed field widths of the stream items.
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 10;
    localparam int MIN_LEN_W  = 11;
    localparam int URL_LEN_W  = 10;
    localparam int HOST_LEN_W = 8;
    localparam int CMP_W      = (CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W;

    // Packed stream widths (padded to whole bytes).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(32);

    // Pattern lengths in bytes.
    localparam int GET_LEN  = 4;
    localparam int POST_LEN = 5;
    localparam int HTTP_LEN = 8;
    localparam int HOST_LEN = 8;
    localparam int CRLF_LEN = 2;

    // Byte patterns, most recent byte in the lowest bits.
    localparam logic [63:0] PAT_HTTP = 64'h2048_5454_502F_312E;
    localparam logic [63:0] PAT_HOST = 64'h0D0A_486F_7374_3A20;
    localparam logic [15:0] PAT_CRLF = 16'h0D0A;
    localparam logic [31:0] PAT_GET  = 32'h4745_5420;
    localparam logic [39:0] PAT_POST = 40'h50_4F53_5420;

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PAYLOAD   = 2'd0,
        CMD_READ_URL  = 2'd1,
        CMD_READ_HOST = 2'd2,
        CMD_IGNORE    = 2'd3
    } command_t;

    // Result kinds.
    typedef enum logic {
        KIND_READ    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // Store write request from the parser.
    typedef struct packed {
        logic               url_we;
        logic [URL_AW-1:0]  url_addr;
        logic               host_we;
        logic [HOST_AW-1:0] host_addr;
        logic [BYTE_W-1:0]  data;
    } store_wr_t;

    // End-of-packet summary fields.
    typedef struct packed {
        logic                  is_request;
        logic                  url_found;
        logic [URL_LEN_W-1:0]  url_length;
        logic                  host_found;
        logic [HOST_LEN_W-1:0] host_length;
    } summary_t;

endpackage

`default_nettype wire

// File: design/hrx_parser.sv
// ---------------------------------------------------------------------------
// hrx_parser
// Per-packet tracker: byte window, method decode, URL and Host searches,
// store write generation and the end-of-packet summary.
// ---------------------------------------------------------------------------
`default_nettype none

module hrx_parser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step_valid,
    input  wire logic [hrx_pkg::BYTE_W-1:0]      step_byte,
    input  wire logic                            step_last,
    input  wire logic [hrx_pkg::MIN_LEN_W-1:0]   min_len,
    output hrx_pkg::store_wr_t                   wr,
    output hrx_pkg::summary_t                    summary
);

    typedef enum logic [1:0] {
        METH_UNDECIDED = 2'd0,
        METH_GET       = 2'd1,
        METH_POST      = 2'd2,
        METH_NONE      = 2'd3
    } method_t;

    typedef enum logic [1:0] {
        URL_SRCH   = 2'd0,
        URL_FOUND  = 2'd1,
        URL_FAILED = 2'd2
    } url_status_t;

    typedef enum logic [1:0] {
        HOST_HDR    = 2'd0,
        HOST_VALUE  = 2'd1,
        HOST_FOUND  = 2'd2,
        HOST_FAILED = 2'd3
    } host_phase_t;

    localparam int CW  = hrx_pkg::CNT_W;
    localparam int CW1 = hrx_pkg::CNT1_W;

    logic [63:0]                      window_reg, window_next;
    logic [CW-1:0]                    count_reg, count_next;
    method_t                          method_reg, method_next;
    url_status_t                      url_status_reg, url_status_next;
    logic [hrx_pkg::URL_LEN_W-1:0]    url_len_reg, url_len_next;
    host_phase_t                      host_phase_reg, host_phase_next;
    logic [CW-1:0]                    host_start_reg, host_start_next;
    logic [hrx_pkg::HOST_LEN_W-1:0]   host_len_reg, host_len_next;

    logic [63:0]   shifted;
    logic [CW-1:0] pos;
    logic [CW-1:0] n;
    logic          take;
    logic          is_req;
    logic [CW-1:0] url_start;
    logic [CW-1:0] url_idx;
    logic [CW-1:0] url_full_len;
    logic [CW-1:0] host_idx;
    logic [CW-1:0] host_full_len;
    logic          sum_req;

    // Next-state logic for one payload byte.
    always_comb begin
        window_next     = window_reg;
        count_next      = count_reg;
        method_next     = method_reg;
        url_status_next = url_status_reg;
        url_len_next    = url_len_reg;
        host_phase_next = host_phase_reg;
        host_start_next = host_start_reg;
        host_len_next   = host_len_reg;

        wr      = '0;
        wr.data = step_byte;

        pos     = count_reg;
        n       = count_reg + CW'(1);
        shifted = {window_reg[55:0], step_byte};
        take    = step_valid && (32'(count_reg) < hrx_pkg::PAYLOAD_MAX);

        // Method decode on the fourth and fifth bytes.
        if (take) begin
            window_next = shifted;
            count_next  = n;
            if (pos == CW'(hrx_pkg::GET_LEN - 1) && shifted[31:0] == hrx_pkg::PAT_GET) begin
                method_next = METH_GET;
            end else if (pos == CW'(hrx_pkg::POST_LEN - 1) && method_reg == METH_UNDECIDED) begin
                method_next = (shifted[39:0] == hrx_pkg::PAT_POST) ? METH_POST : METH_NONE;
            end
        end

        is_req    = (method_next == METH_GET) || (method_next == METH_POST);
        url_start = (method_next == METH_GET) ? CW'(hrx_pkg::GET_LEN) : CW'(hrx_pkg::POST_LEN);
        url_idx   = pos - url_start;
        url_full_len  = n - CW'(hrx_pkg::HTTP_LEN) - url_start;
        host_idx      = pos - host_start_reg;
        host_full_len = n - CW'(hrx_pkg::CRLF_LEN) - host_start_reg;

        // URL capture until the first " HTTP/1." after the method.
        if (take && is_req && url_status_reg == URL_SRCH) begin
            if (pos >= url_start && 32'(url_idx) < hrx_pkg::URL_MAX) begin
                wr.url_we   = 1'b1;
                wr.url_addr = hrx_pkg::URL_AW'(url_idx);
            end
            if ({1'b0, n} >= {1'b0, url_start} + CW1'(hrx_pkg::HTTP_LEN)
                    && shifted == hrx_pkg::PAT_HTTP) begin
                url_len_next    = hrx_pkg::URL_LEN_W'(url_full_len);
                url_status_next = (32'(url_full_len) < hrx_pkg::URL_MAX) ? URL_FOUND
                                                                         : URL_FAILED;
            end
        end

        // Host header search, then value capture up to the line end.
        if (take) begin
            if (host_phase_reg == HOST_VALUE) begin
                if (is_req && 32'(host_idx) < hrx_pkg::HOST_MAX) begin
                    wr.host_we   = 1'b1;
                    wr.host_addr = hrx_pkg::HOST_AW'(host_idx);
                end
                if ({1'b0, n} >= {1'b0, host_start_reg} + CW1'(hrx_pkg::CRLF_LEN)
                        && shifted[15:0] == hrx_pkg::PAT_CRLF) begin
                    host_len_next   = hrx_pkg::HOST_LEN_W'(host_full_len);
                    host_phase_next = (32'(host_full_len) < hrx_pkg::HOST_MAX) ? HOST_FOUND
                                                                               : HOST_FAILED;
                end
            end else if (host_phase_reg == HOST_HDR) begin
                if (32'(n) >= hrx_pkg::HOST_LEN && shifted == hrx_pkg::PAT_HOST) begin
                    host_phase_next = HOST_VALUE;
                    host_start_next = n;
                end
            end
        end

        // Summary from the state after this byte.
        sum_req = is_req
                  && (hrx_pkg::CMP_W'(count_next) > hrx_pkg::CMP_W'(min_len));
        summary            = '0;
        summary.is_request = sum_req;
        if (sum_req && url_status_next == URL_FOUND) begin
            summary.url_found  = 1'b1;
            summary.url_length = url_len_next;
        end
        if (sum_req && host_phase_next == HOST_FOUND) begin
            summary.host_found  = 1'b1;
            summary.host_length = host_len_next;
        end
    end

    // Packet state; the last byte clears it for the next packet.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_valid && step_last)) begin
            window_reg     <= '0;
            count_reg      <= '0;
            method_reg     <= METH_UNDECIDED;
            url_status_reg <= URL_SRCH;
            url_len_reg    <= '0;
            host_phase_reg <= HOST_HDR;
            host_start_reg <= '0;
            host_len_reg   <= '0;
        end else if (step_valid) begin
            window_reg     <= window_next;
            count_reg      <= count_next;
            method_reg     <= method_next;
            url_status_reg <= url_status_next;
            url_len_reg    <= url_len_next;
            host_phase_reg <= host_phase_next;
            host_start_reg <= host_start_next;
            host_len_reg   <= host_len_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hrx_store.sv
// ---------------------------------------------------------------------------
// hrx_store
// URL and Host byte memories with one write port each and a registered
// read port shared by the two read commands.
// ---------------------------------------------------------------------------
`default_nettype none

module hrx_store (
    input  wire logic                           aclk,
    input  wire hrx_pkg::store_wr_t             wr,
    input  wire logic                           rd_en,
    input  wire hrx_pkg::command_t              rd_cmd,
    input  wire logic [hrx_pkg::INDEX_W-1:0]    rd_index,
    output logic [hrx_pkg::BYTE_W-1:0]          rd_data
);

    logic [hrx_pkg::BYTE_W-1:0] url_mem  [hrx_pkg::URL_MAX];
    logic [hrx_pkg::BYTE_W-1:0] host_mem [hrx_pkg::HOST_MAX];

    logic [hrx_pkg::BYTE_W-1:0] url_rd_reg;
    logic [hrx_pkg::BYTE_W-1:0] host_rd_reg;
    logic                       sel_url_reg;
    logic                       in_range_reg;

    // Byte writes from the parser.
    always_ff @(posedge aclk) begin
        if (wr.url_we) begin
            url_mem[wr.url_addr] <= wr.data;
        end
        if (wr.host_we) begin
            host_mem[wr.host_addr] <= wr.data;
        end
    end

    // Registered reads; the result stays until the next read beat.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            url_rd_reg   <= url_mem[hrx_pkg::URL_AW'(rd_index)];
            host_rd_reg  <= host_mem[hrx_pkg::HOST_AW'(rd_index)];
            sel_url_reg  <= (rd_cmd == hrx_pkg::CMD_READ_URL);
            in_range_reg <= (rd_cmd == hrx_pkg::CMD_READ_URL)
                            ? (32'(rd_index) < hrx_pkg::URL_MAX)
                            : (32'(rd_index) < hrx_pkg::HOST_MAX);
        end
    end

    // An index beyond the store size reads as zero.
    assign rd_data = !in_range_reg ? '0 : (sel_url_reg ? url_rd_reg : host_rd_reg);

endmodule

`default_nettype wire

// File: design/http_request_url_host_extractor.sv
// ---------------------------------------------------------------------------
// http_request_url_host_extractor
// Finds GET/POST requests in a TCP payload byte stream, stores the URL and
// the Host value, reports a summary on the last byte and serves stored bytes.
// ---------------------------------------------------------------------------
//  Channel   Direction  Moves per beat
//  s_axis    in         one payload byte or one store read command
//  m_axis    out        one read reply or one end-of-packet summary
//  cfg       in         minimum payload length register
//
//  One beat is taken per cycle while the held beat can move on. A beat
//  passes an input register, then the parser and store logic, then the
//  result register, from which its result is offered on m_axis. Payload
//  bytes that produce no result never wait on m_axis; a result beat waits
//  only while the result register is full and not taken. Reset clears the
//  packet state and sets the minimum length to 32; the stores keep their
//  contents and need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_request_url_host_extractor_assert.svh"

module http_request_url_host_extractor (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] data_byte, [17:8] read_index, [23:18] zero.
    input  wire logic [hrx_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] command.
    input  wire logic [hrx_pkg::CMD_W-1:0]         s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] read_data, [8] is_request, [9] url_found, [19:10] url_length,
    // [20] host_found, [28:21] host_length, [31:29] zero.
    output logic [hrx_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // [0] result_kind.
    output logic                                   m_axis_tuser,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hrx_pkg::MIN_LEN_W-1:0]     cfg_data
);

    logic [hrx_pkg::MIN_LEN_W-1:0] min_len_reg;

    logic                          in_valid_reg;
    hrx_pkg::command_t             in_cmd_reg;
    logic [hrx_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_last_reg;
    logic [hrx_pkg::INDEX_W-1:0]   in_index_reg;

    logic                          out_valid_reg;
    hrx_pkg::kind_t                out_kind_reg;
    hrx_pkg::summary_t             out_sum_reg;

    logic                          in_has_result;
    logic                          in_adv;
    logic                          step_valid;
    logic                          rd_en;
    hrx_pkg::store_wr_t            wr;
    hrx_pkg::summary_t             summary;
    logic [hrx_pkg::BYTE_W-1:0]    rd_data;
    logic [hrx_pkg::BYTE_W-1:0]    out_read_data;

    // Configuration register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= hrx_pkg::MIN_LEN_RESET;
        end else if (cfg_valid) begin
            min_len_reg <= cfg_data;
        end
    end

    // Command decode for the beat held in the input register.
    always_comb begin
        unique case (in_cmd_reg) inside
            hrx_pkg::CMD_PAYLOAD:   in_has_result = in_last_reg;
            hrx_pkg::CMD_READ_URL,
            hrx_pkg::CMD_READ_HOST: in_has_result = 1'b1;
            default:                in_has_result = 1'b0;
        endcase
    end

    // Flow control: the held beat moves on unless its result has no room.
    assign in_adv        = in_valid_reg && (!in_has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_adv;
    assign step_valid    = in_adv && (in_cmd_reg == hrx_pkg::CMD_PAYLOAD);
    assign rd_en         = in_adv && ((in_cmd_reg == hrx_pkg::CMD_READ_URL)
                                      || (in_cmd_reg == hrx_pkg::CMD_READ_HOST));

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg   <= hrx_pkg::command_t'(s_axis_tuser);
            in_byte_reg  <= s_axis_tdata[7:0];
            in_last_reg  <= s_axis_tlast;
            in_index_reg <= s_axis_tdata[17:8];
        end
    end

    hrx_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (step_valid),
        .step_byte  (in_byte_reg),
        .step_last  (in_last_reg),
        .min_len    (min_len_reg),
        .wr         (wr),
        .summary    (summary)
    );

    hrx_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_cmd   (in_cmd_reg),
        .rd_index (in_index_reg),
        .rd_data  (rd_data)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_adv && in_has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && in_has_result) begin
            if (in_cmd_reg == hrx_pkg::CMD_PAYLOAD) begin
                out_kind_reg <= hrx_pkg::KIND_SUMMARY;
                out_sum_reg  <= summary;
            end else begin
                out_kind_reg <= hrx_pkg::KIND_READ;
                out_sum_reg  <= '0;
            end
        end
    end

    // Output packing; read data comes from the store's read register.
    assign out_read_data = (out_kind_reg == hrx_pkg::KIND_READ) ? rd_data : '0;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {3'b000,
                            out_sum_reg.host_length,
                            out_sum_reg.host_found,
                            out_sum_reg.url_length,
                            out_sum_reg.url_found,
                            out_sum_reg.is_request,
                            out_read_data};

    // Checks.
    `HRX_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready)
    `HRX_ASSERT_NEXT(a_last_gives_summary, aclk, aresetn, step_valid && in_last_reg, out_valid_reg && out_kind_reg == hrx_pkg::KIND_SUMMARY)
    `HRX_ASSERT_IMP(a_nonrequest_empty, aclk, aresetn, out_valid_reg && !out_sum_reg.is_request, !out_sum_reg.url_found && !out_sum_reg.host_found && out_sum_reg.url_length == '0 && out_sum_reg.host_length == '0)

endmodule

`default_nettype wire
